FILE: rtl/sst_pkg.sv
// Shared types, constants and helpers for the script source tokenizer.
package sst_pkg;

  // Internal width of byte positions and token lengths.
  localparam int unsigned PosW = 16;
  localparam int unsigned OutW = 16;

  // Token queue between the scanner and the output stage.
  localparam int unsigned MaxTok = 3;
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Keyword indexes into the candidate mask.
  localparam logic [1:0] KW_FN     = 2'd0;
  localparam logic [1:0] KW_RETURN = 2'd1;
  localparam logic [1:0] KW_INT    = 2'd2;
  localparam int unsigned NumKw    = 3;

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t PosMax = '1;

  typedef enum logic [2:0] {
    KIND_KEYWORD  = 3'd0,
    KIND_IDENT    = 3'd1,
    KIND_NUMBER   = 3'd2,
    KIND_OPERATOR = 3'd3,
    KIND_STRING   = 3'd4,
    KIND_EOF      = 3'd5
  } tok_kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_IDENT  = 6'b000010,
    MODE_NUMBER = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_ESCAPE = 6'b010000,
    MODE_DONE   = 6'b100000
  } scan_mode_e;

  // Input transaction.
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [2:0]      token_kind;
    logic [OutW-1:0] start_offset;
    logic [OutW-1:0] token_length;
    logic            last_token;
  } out_item_t;

  // Token at internal width, as it travels through the queue.
  typedef struct packed {
    tok_kind_e kind;
    pos_t      start;
    pos_t      len;
    logic      last;
  } tok_t;

  // Tokens produced by one accepted byte, packed from slot zero.
  typedef struct packed {
    logic [1:0]             cnt;
    tok_t [MaxTok-1:0]      tok;
  } tok_wr_t;

  // Saturating increment of a position or length.
  function automatic pos_t sat_inc(pos_t v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  // Clip an internal position to the output field width.
  function automatic logic [OutW-1:0] clip_out(pos_t v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(17'h0FFFF)) begin
      return '1;
    end
    return wide[OutW-1:0];
  endfunction

  // Keyword lengths.
  function automatic logic [2:0] kw_len(logic [1:0] k);
    case (k)
      KW_FN:     return 3'd2;
      KW_RETURN: return 3'd6;
      KW_INT:    return 3'd3;
      default:   return 3'd0;
    endcase
  endfunction

  // Keyword characters; positions past the end read as zero.
  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] i);
    case ({k, i})
      {KW_FN, 3'd0}:     return "f";
      {KW_FN, 3'd1}:     return "n";
      {KW_RETURN, 3'd0}: return "r";
      {KW_RETURN, 3'd1}: return "e";
      {KW_RETURN, 3'd2}: return "t";
      {KW_RETURN, 3'd3}: return "u";
      {KW_RETURN, 3'd4}: return "r";
      {KW_RETURN, 3'd5}: return "n";
      {KW_INT, 3'd0}:    return "i";
      {KW_INT, 3'd1}:    return "n";
      {KW_INT, 3'd2}:    return "t";
      default:           return 8'h00;
    endcase
  endfunction

  // Keywords that still agree with character c at index idx.
  function automatic logic [NumKw-1:0] kw_match(logic [7:0] c, pos_t idx);
    logic [NumKw-1:0] hit;
    for (int k = 0; k < NumKw; k++) begin
      hit[k] = (32'(idx) < 32'(kw_len(2'(k)))) && (kw_char(2'(k), idx[2:0]) == c);
    end
    return hit;
  endfunction

  // A surviving candidate whose length equals the identifier length.
  function automatic logic kw_found(logic [NumKw-1:0] cand, pos_t len);
    logic found;
    found = 1'b0;
    for (int k = 0; k < NumKw; k++) begin
      if (cand[k] && (32'(len) == 32'(kw_len(2'(k))))) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

endpackage

FILE: rtl/sst_front.sv
// Scanner: classifies each source byte, tracks the pending token and emits tokens.
module sst_front import sst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output tok_wr_t  wr_o
);

  scan_mode_e       mode_q, mode_d;
  pos_t             pos_q, pos_d;
  pos_t             pstart_q, pstart_d;
  pos_t             plen_q, plen_d;
  logic [NumKw-1:0] cand_q, cand_d;

  // Working values after the byte is handled, before the end flag.
  scan_mode_e       m_w;
  pos_t             ps_w, pl_w, pos_w;
  logic [NumKw-1:0] cd_w;
  logic             go_idle;

  logic [7:0] c;
  logic       is_letter, is_digit, is_op, is_quote, is_bslash, is_nul, is_last;

  tok_t [MaxTok-1:0] slot;
  logic [MaxTok-1:0] slot_v;

  assign c         = item_i.source_byte;
  assign is_last   = item_i.end_of_source;
  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  assign is_digit  = (c >= "0" && c <= "9");
  assign is_op     = (c == "(") || (c == ")") || (c == "{") || (c == "}") ||
                     (c == ";") || (c == "=");
  assign is_quote  = (c == "\"");
  assign is_bslash = (c == "\\");
  assign is_nul    = (c == 8'h00);

  function automatic logic has_pending(scan_mode_e m);
    return (m == MODE_IDENT) || (m == MODE_NUMBER) || (m == MODE_STRING) ||
           (m == MODE_ESCAPE);
  endfunction

  // Token for the pending run in mode m.
  function automatic tok_t flush_tok(scan_mode_e m, pos_t ps, pos_t pl,
                                     logic [NumKw-1:0] cd);
    tok_t t;
    t.start = ps;
    t.len   = pl;
    t.last  = 1'b0;
    case (m)
      MODE_IDENT:  t.kind = kw_found(cd, pl) ? KIND_KEYWORD : KIND_IDENT;
      MODE_NUMBER: t.kind = KIND_NUMBER;
      default:     t.kind = KIND_STRING;
    endcase
    return t;
  endfunction

  // Step the scanner for one accepted byte.
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    cand_d   = cand_q;
    m_w      = mode_q;
    ps_w     = pstart_q;
    pl_w     = plen_q;
    cd_w     = cand_q;
    pos_w    = sat_inc(pos_q);
    go_idle  = 1'b0;
    slot     = '0;
    slot_v   = '0;

    if (accept_i) begin
      if (mode_q == MODE_DONE) begin
        if (is_last) begin
          mode_d   = MODE_IDLE;
          pos_d    = '0;
          pstart_d = '0;
          plen_d   = '0;
          cand_d   = '1;
        end
      end else if (is_nul) begin
        // flush, then end of file at the zero byte's position
        slot_v[0] = has_pending(mode_q);
        slot[0]   = flush_tok(mode_q, pstart_q, plen_q, cand_q);
        slot_v[2] = 1'b1;
        slot[2]   = '{kind: KIND_EOF, start: pos_q, len: '0, last: 1'b1};
        if (is_last) begin
          mode_d   = MODE_IDLE;
          pos_d    = '0;
          pstart_d = '0;
          plen_d   = '0;
          cand_d   = '1;
        end else begin
          mode_d = MODE_DONE;
        end
      end else begin
        case (mode_q)
          MODE_IDENT: begin
            if (is_letter || is_digit) begin
              cd_w = cand_q & kw_match(c, plen_q);
              pl_w = sat_inc(plen_q);
            end else begin
              slot_v[0] = 1'b1;
              slot[0]   = flush_tok(mode_q, pstart_q, plen_q, cand_q);
              go_idle   = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (is_digit) begin
              pl_w = sat_inc(plen_q);
            end else begin
              slot_v[0] = 1'b1;
              slot[0]   = flush_tok(mode_q, pstart_q, plen_q, cand_q);
              go_idle   = 1'b1;
            end
          end
          MODE_STRING: begin
            if (is_quote) begin
              slot_v[0] = 1'b1;
              slot[0]   = flush_tok(mode_q, pstart_q, plen_q, cand_q);
              m_w       = MODE_IDLE;
            end else begin
              pl_w = sat_inc(plen_q);
              if (is_bslash) begin
                m_w = MODE_ESCAPE;
              end
            end
          end
          MODE_ESCAPE: begin
            pl_w = sat_inc(plen_q);
            m_w  = MODE_STRING;
          end
          default: begin
            go_idle = 1'b1;
          end
        endcase

        // start a new token from between tokens
        if (go_idle) begin
          m_w = MODE_IDLE;
          if (is_letter) begin
            m_w  = MODE_IDENT;
            ps_w = pos_q;
            cd_w = kw_match(c, '0);
            pl_w = pos_t'(1);
          end else if (is_digit) begin
            m_w  = MODE_NUMBER;
            ps_w = pos_q;
            pl_w = pos_t'(1);
          end else if (is_op) begin
            slot_v[1] = 1'b1;
            slot[1]   = '{kind: KIND_OPERATOR, start: pos_q, len: pos_t'(1), last: 1'b0};
          end else if (is_quote) begin
            m_w  = MODE_STRING;
            ps_w = sat_inc(pos_q);
            pl_w = '0;
          end
        end

        if (is_last) begin
          // flush what is left, close the run and return to reset state
          if (has_pending(m_w)) begin
            slot_v[1] = 1'b1;
            slot[1]   = flush_tok(m_w, ps_w, pl_w, cd_w);
          end
          slot_v[2] = 1'b1;
          slot[2]   = '{kind: KIND_EOF, start: pos_w, len: '0, last: 1'b1};
          mode_d    = MODE_IDLE;
          pos_d     = '0;
          pstart_d  = '0;
          plen_d    = '0;
          cand_d    = '1;
        end else begin
          mode_d   = m_w;
          pos_d    = pos_w;
          pstart_d = ps_w;
          plen_d   = pl_w;
          cand_d   = cd_w;
        end
      end
    end
  end

  // Pack valid slots in order.
  always_comb begin
    wr_o = '0;
    for (int i = 0; i < MaxTok; i++) begin
      if (slot_v[i]) begin
        wr_o.tok[wr_o.cnt] = slot[i];
        wr_o.cnt           = wr_o.cnt + 2'd1;
      end
    end
  end

  // Hold scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      cand_q   <= '1;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      cand_q   <= cand_d;
    end
  end

endmodule

FILE: rtl/sst_queue.sv
// Token queue: takes up to three tokens per cycle, gives one per cycle.
module sst_queue import sst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  tok_wr_t wr_i,
  output logic    full_o,
  input  logic    deq_i,
  output logic    head_valid_o,
  output tok_t    head_o
);

  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  // Full once a byte's worth of tokens might not fit.
  assign full_o       = (count_q > QCntW'(QDepth - MaxTok));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + QPtrW'(wr_i.cnt);
  assign rd_ptr_d = rd_ptr_q + QPtrW'(deq_i);
  assign count_d  = count_q + QCntW'(wr_i.cnt) - QCntW'(deq_i);

  // Write incoming tokens at consecutive slots.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxTok; i++) begin
      if (2'(i) < wr_i.cnt) begin
        mem_q[wr_ptr_q + QPtrW'(i)] <= wr_i.tok[i];
      end
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/sst_back.sv
// Output stage: clips tokens to field width and holds the result transaction.
module sst_back import sst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  tok_t      head_i,
  output logic      deq_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  logic      valid_q, valid_d;
  out_item_t out_q;

  // Refill when the register is free or being taken.
  assign deq_o   = head_valid_i && (!valid_q || pop_i);
  assign valid_d = deq_o || (valid_q && !pop_i);

  assign empty_o    = !valid_q;
  assign out_item_o = out_q;

  // Load clipped token.
  always_ff @(posedge clk_i) begin
    if (deq_o) begin
      out_q.token_kind   <= head_i.kind;
      out_q.start_offset <= clip_out(head_i.start);
      out_q.token_length <= clip_out(head_i.len);
      out_q.last_token   <= head_i.last;
    end
  end

  // Track output occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

FILE: rtl/script_source_tokenizer_unit.sv
// Streaming tokenizer for script source text: scanner, token queue, output stage.
//
// Usage: source bytes enter through a queue-style port. A transaction is taken
// at a rising edge with push high and full low; in_item_i carries the byte and
// the end_of_source flag. Tokens leave through a second queue-style port: while
// empty is low the oldest token sits on out_item_o, and it is taken at a rising
// edge with pop high and empty low.
// Throughput: one source byte per cycle while full is low. A byte may produce up
// to three tokens (pending token, operator or token begun by the byte, end of
// file); the token queue holds eight and drains one per cycle while the output
// register is free or popped, and full rises while it holds six or more.
// A completed token passes through the queue into the output register.
// A stalled receiver holds the current token on the outputs; the queue fills
// and full then holds off new bytes without losing anything.
// Reset clears the scanner to between tokens at offset zero and empties the
// queue and output register. After end_of_source the scanner returns to that
// state by itself for the next source text.
module script_source_tokenizer_unit import sst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  tok_wr_t wr;
  logic    q_full;
  logic    deq;
  logic    head_valid;
  tok_t    head;
  logic    accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Classify bytes and form tokens.
  sst_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .wr_o     (wr)
  );

  // Buffer tokens between scanner and output.
  sst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .full_o       (q_full),
    .deq_i        (deq),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Present tokens to the receiver.
  sst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .deq_o        (deq),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_item_o   (out_item_o)
  );

endmodule
